[rtl/core/tlfr_pkg.sv]
`default_nettype none

package tlfr_pkg;

  // Store sizing
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned PosW       = 6;

  // Register reset value
  localparam logic [15:0] TimeoutRst = 16'd10;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  // Controller mode
  typedef enum logic [1:0] {
    MODE_RUN   = 2'b01,
    MODE_DRAIN = 2'b10
  } mode_e;

  // One result word
  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      frame_kind;
    logic [7:0]      frame_size;
    logic [7:0]      value;
    logic [PosW-1:0] position;
    logic            last;
  } result_t;

  // Payload store access
  typedef struct packed {
    logic            we;
    logic [PosW-1:0] waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [PosW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[rtl/core/type_length_frame_receiver_core.sv]
// Type-length frame receiver.
// Input channel (in_valid_i/in_ready_o): one word per serial byte
// (command_i = 0, rx_byte_i) or per millisecond tick (command_i = 1).
// Frames are a type byte, a length byte and that many payload bytes.
// Output channel (out_valid_o/out_ready_i): result words. An empty frame
// gives one word, a frame longer than the store gives one dropped word,
// a complete frame gives one word per payload byte, last one marked.
// cfg_we_i/cfg_wdata_i write the per-byte timeout in milliseconds; ticks
// count the silence counter down and a timeout returns parsing to idle.
// A single result is loaded into the output register in the cycle
// after its input word. A payload drain passes through the mode
// register, the store's registered read and the output register, then
// gives one byte per cycle while the output takes them; the input stays
// closed until the drain ends. The drain rate is set by the single
// registered read port of the payload store.
// Reset clears the parser to idle, the silence counter to zero and the
// timeout register to 10; the payload store is not cleared.
// When the receiver stalls, the output register holds its word and the
// input closes until that word is taken.
`default_nettype none

module type_length_frame_receiver_core #(
  parameter int unsigned MAX_PAYLOAD = tlfr_pkg::MaxPayload
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       frame_kind_o,
  output logic [7:0]       frame_size_o,
  output logic [7:0]       payload_value_o,
  output logic [5:0]       payload_position_o,
  output logic             last_o
);
  import tlfr_pkg::*;

  logic [15:0] timeout_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        out_free;
  logic        res_push;
  result_t     res;
  mem_req_t    mem_req;
  logic [7:0]  mem_rdata;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  tlfr_ctrl #(
    .MaxPayload(MAX_PAYLOAD)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .rx_byte_i  (rx_byte_i),
    .timeout_i  (timeout_q),
    .out_free_i (out_free),
    .res_push_o (res_push),
    .res_o      (res),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  tlfr_store #(
    .Depth(MAX_PAYLOAD)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  // Output register: load a new word or drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_q.kind;
  assign frame_kind_o       = out_q.frame_kind;
  assign frame_size_o       = out_q.frame_size;
  assign payload_value_o    = out_q.value;
  assign payload_position_o = out_q.position;
  assign last_o             = out_q.last;

endmodule

`default_nettype wire

[rtl/core/tlfr_store.sv]
`default_nettype none

module tlfr_store #(
  parameter int unsigned Depth = 64
) (
  input  wire logic               clk_i,
  input  wire tlfr_pkg::mem_req_t req_i,
  output logic [7:0]              rdata_o
);
  import tlfr_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Write one payload byte
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AddrW-1:0]] <= req_i.wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AddrW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/tlfr_ctrl.sv]
`default_nettype none

module tlfr_ctrl #(
  parameter int unsigned MaxPayload = tlfr_pkg::MaxPayload
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic [15:0]        timeout_i,
  input  wire logic               out_free_i,
  output logic                    res_push_o,
  output tlfr_pkg::result_t       res_o,
  output tlfr_pkg::mem_req_t      mem_req_o,
  input  wire logic [7:0]         mem_rdata_i
);
  import tlfr_pkg::*;

  localparam logic [7:0] LenMax = 8'(MaxPayload);

  phase_e      phase_q, phase_d;
  mode_e       mode_q, mode_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  taken_q, taken_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  iss_q, iss_d;
  logic [7:0]  pos_q, pos_d;
  logic        dv_q, dv_d;

  logic        accept;
  logic [7:0]  mul_len;
  logic [23:0] prod;
  logic [15:0] long_reload;
  logic [7:0]  taken_inc;
  logic        single_push;
  logic [1:0]  single_kind;
  logic        drain_push;
  logic        issue;

  assign in_ready_o = (mode_q == MODE_RUN) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  // Per-byte timeout times length, saturated
  assign mul_len     = (phase_q == PH_LEN) ? rx_byte_i : len_q;
  assign prod        = 24'(timeout_i) * 24'(mul_len);
  assign long_reload = (prod[23:16] != 8'd0) ? 16'hFFFF : prod[15:0];
  assign taken_inc   = taken_q + 8'd1;

  // Drain: read ahead one entry, hold it until the output takes it
  assign drain_push = (mode_q == MODE_DRAIN) && dv_q && out_free_i;
  assign issue      = (mode_q == MODE_DRAIN) && (iss_q < len_q) && (!dv_q || drain_push);

  // Parse bytes, run the silence counter, sequence the drain
  always_comb begin
    phase_d     = phase_q;
    mode_d      = mode_q;
    type_d      = type_q;
    len_d       = len_q;
    taken_d     = taken_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    pos_d       = pos_q;
    dv_d        = dv_q;
    single_push = 1'b0;
    single_kind = KIND_EMPTY;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = taken_q[PosW-1:0];
    mem_req_o.wdata = rx_byte_i;
    mem_req_o.re    = issue;
    mem_req_o.raddr = iss_q[PosW-1:0];

    if (accept) begin
      if (command_i == CMD_TICK) begin
        if (cnt_q != 16'd0) begin
          cnt_d = cnt_q - 16'd1;
          if (cnt_q == 16'd1) begin
            phase_d = PH_IDLE;
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            type_d  = rx_byte_i;
            taken_d = 8'd0;
            cnt_d   = timeout_i;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d   = rx_byte_i;
            taken_d = 8'd0;
            cnt_d   = long_reload;
            if (rx_byte_i == 8'd0) begin
              single_push = 1'b1;
              single_kind = KIND_EMPTY;
              phase_d     = PH_IDLE;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            cnt_d        = (taken_q == 8'd0) ? timeout_i : long_reload;
            mem_req_o.we = (taken_q < LenMax);
            taken_d      = taken_inc;
            if (taken_inc >= len_q) begin
              phase_d = PH_IDLE;
              if (len_q > LenMax) begin
                single_push = 1'b1;
                single_kind = KIND_DROP;
              end else begin
                mode_d = MODE_DRAIN;
                iss_d  = 8'd0;
                dv_d   = 1'b0;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    // Advance the read pointer or drop the taken entry
    if (issue) begin
      dv_d  = 1'b1;
      pos_d = iss_q;
      iss_d = iss_q + 8'd1;
    end else if (drain_push) begin
      dv_d = 1'b0;
    end
    if (drain_push && ((pos_q + 8'd1) == len_q)) begin
      mode_d = MODE_RUN;
    end
  end

  // Result word
  always_comb begin
    res_o.frame_kind = type_q;
    res_o.frame_size = len_q;
    if (mode_q == MODE_DRAIN) begin
      res_o.kind     = KIND_BYTE;
      res_o.value    = mem_rdata_i;
      res_o.position = pos_q[PosW-1:0];
      res_o.last     = ((pos_q + 8'd1) == len_q);
    end else begin
      res_o.kind     = single_kind;
      res_o.value    = 8'd0;
      res_o.position = '0;
      res_o.last     = 1'b1;
    end
    // The empty-frame result carries the length just taken
    if (single_push) begin
      res_o.frame_size = len_d;
    end
  end

  assign res_push_o = single_push || drain_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mode_q  <= MODE_RUN;
      type_q  <= 8'd0;
      len_q   <= 8'd0;
      taken_q <= 8'd0;
      cnt_q   <= 16'd0;
      iss_q   <= 8'd0;
      pos_q   <= 8'd0;
      dv_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      type_q  <= type_d;
      len_q   <= len_d;
      taken_q <= taken_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pos_q   <= pos_d;
      dv_q    <= dv_d;
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tlfr_pkg::*;

  localparam int unsigned CycleLimit  = 500_000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettlePause = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        command_i   = CMD_TICK;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  result_kind_o;
  logic [7:0]  frame_kind_o;
  logic [7:0]  frame_size_o;
  logic [7:0]  payload_value_o;
  logic [5:0]  payload_position_o;
  logic        last_o;

  // Parser state as the block should hold it
  logic [15:0] per_byte_ms = TimeoutRst;
  phase_e      parse_phase = PH_IDLE;
  logic [7:0]  held_type   = 8'h00;
  logic [7:0]  held_len    = 8'h00;
  logic [7:0]  taken       = 8'h00;
  logic [15:0] silence_ms  = 16'h0000;
  logic [7:0]  payload_copy [MaxPayload];
  result_t     pending_results [$];

  bit          sender_quiet   = 1'b0;
  bit          receiver_quiet = 1'b0;
  bit          hold_req       = 1'b0;
  bit          holding        = 1'b0;
  int unsigned words_used     = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  type_length_frame_receiver_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .rx_byte_i          (rx_byte_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .frame_kind_o       (frame_kind_o),
    .frame_size_o       (frame_size_o),
    .payload_value_o    (payload_value_o),
    .payload_position_o (payload_position_o),
    .last_o             (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Abort a run that has hung
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 15);
    else return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] long_reload();
    logic [23:0] prod;
    prod = 24'(per_byte_ms) * 24'(held_len);
    return (prod > 24'hFFFF) ? 16'hFFFF : prod[15:0];
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] value,
                                      input logic [5:0] pos, input logic last);
    result_t r;
    r.kind       = kind;
    r.frame_kind = held_type;
    r.frame_size = held_len;
    r.value      = value;
    r.position   = pos;
    r.last       = last;
    pending_results.push_back(r);
  endfunction

  // Advance the parser by one accepted word and queue the results it owes
  task automatic parse_word(input logic cmd, input logic [7:0] b);
    if (cmd == CMD_TICK) begin
      if (silence_ms != 16'h0000) begin
        silence_ms = silence_ms - 16'd1;
        if (silence_ms == 16'h0000) parse_phase = PH_IDLE;
      end
    end else begin
      case (parse_phase)
        PH_IDLE: begin
          held_type   = b;
          taken       = 8'h00;
          silence_ms  = per_byte_ms;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          held_len   = b;
          taken      = 8'h00;
          silence_ms = long_reload();
          if (held_len == 8'h00) begin
            push_result(KIND_EMPTY, 8'h00, 6'd0, 1'b1);
            parse_phase = PH_IDLE;
          end else begin
            parse_phase = PH_DATA;
          end
        end
        default: begin
          silence_ms = (taken == 8'h00) ? per_byte_ms : long_reload();
          if (taken < MaxPayload) payload_copy[taken[5:0]] = b;
          taken = taken + 8'd1;
          if (taken >= held_len) begin
            if (held_len > MaxPayload) begin
              push_result(KIND_DROP, 8'h00, 6'd0, 1'b1);
            end else begin
              for (int i = 0; i < held_len; i++)
                push_result(KIND_BYTE, payload_copy[i], 6'(i), (i + 1 == held_len));
            end
            parse_phase = PH_IDLE;
          end
        end
      endcase
    end
  endtask

  // Offer one word, hold it until taken, then predict; returns at a falling edge
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_BYTE || silence_ms != 16'h0000) words_used++;
    parse_word(cmd, b);
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(CMD_BYTE, b);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(CMD_TICK, 8'($urandom_range(255)));
  endtask

  // Type, length and random payload, with ticks scattered in at tick_pct percent
  task automatic send_frame(input logic [7:0] kind, input logic [7:0] len,
                            input int unsigned tick_pct);
    send_byte(kind);
    if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(1, 2));
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(1, 2));
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // Drop valid and let every owed result come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettlePause) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] ms);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    per_byte_ms = ms;
    @(negedge clk_i);
  endtask

  // Reset timeout, empty frame, short frames with extreme bytes
  task automatic test_basic_frames();
    send_ticks(2);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'h03);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
  endtask

  // Abort after type, in payload, count down while idle, and no timeout at zero
  task automatic test_silence_timeouts();
    wait_idle();
    write_timeout(16'd1);
    send_byte(8'h11);
    send_ticks(1);
    send_byte(8'h22);
    send_byte(8'h02);
    send_ticks(1);
    send_byte(8'hC0);
    send_ticks(1);
    send_frame(8'h33, 8'd1, 0);
    send_ticks(3);
    wait_idle();
    write_timeout(16'd0);
    send_frame(8'h44, 8'd2, 100);
    send_ticks(2);
  endtask

  // Saturated reload on a frame just too long for the store
  task automatic test_long_frames();
    wait_idle();
    write_timeout(16'hFFFF);
    send_frame(8'hC3, 8'd65, 2);
  endtask

  // Fill the store and hold the output off long enough that the input must close
  task automatic test_output_stall();
    wait_idle();
    write_timeout(16'd300);
    sender_quiet = 1'b1;
    hold_req     = 1'b1;
    wait (holding);
    send_frame(8'h3C, 8'd64, 0);
    send_frame(8'h3E, 8'd0, 0);
    wait_idle();
    sender_quiet = 1'b0;
  endtask

  // Mostly well-formed frames, with broken frames and stray words mixed in
  task automatic test_random_traffic();
    logic [15:0] phase_ms [4];
    int unsigned start;
    int unsigned r;
    logic [7:0]  len;
    phase_ms[0] = 16'($urandom_range(1, 3));
    phase_ms[1] = 16'd0;
    phase_ms[2] = 16'hFFFF;
    phase_ms[3] = 16'($urandom_range(4, 40));
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_timeout(phase_ms[p]);
      sender_quiet   = (p == 2);
      receiver_quiet = (p == 2);
      start = words_used;
      while (words_used - start < 4) begin
        r = $urandom_range(99);
        if (r < 70) begin
          r = $urandom_range(99);
          if (r < 80) len = 8'($urandom_range(0, 6));
          else len = 8'($urandom_range(7, 20));
          send_frame(8'($urandom_range(255)), len, 5);
        end else if (r < 85) begin
          // cut a frame short and, unless the timeout is zero, send up to 120 ticks toward its timeout
          send_byte(8'($urandom_range(255)));
          if ($urandom_range(1) == 1) begin
            len = 8'($urandom_range(1, 20));
            send_byte(len);
            repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(255)));
          end
          if (per_byte_ms != 16'h0000) send_ticks((silence_ms > 120) ? 120 : silence_ms);
        end else begin
          repeat ($urandom_range(1, 4))
            send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // Drive ready: random stalls, quiet stretches, and one long hold-off on request
  initial begin : ready_driver
    int unsigned span;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        holding = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (receiver_quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        span = pick_gap();
        if (span == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (span - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Compare each result word taken against the oldest one owed
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d, type %0h", result_kind_o, frame_kind_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          error_count++;
        end
        if (frame_kind_o !== want.frame_kind) begin
          $error("frame_kind: expected %0h, got %0h", want.frame_kind, frame_kind_o);
          error_count++;
        end
        if (frame_size_o !== want.frame_size) begin
          $error("frame_size: expected %0d, got %0d", want.frame_size, frame_size_o);
          error_count++;
        end
        if (payload_value_o !== want.value) begin
          $error("payload_value: expected %0h, got %0h", want.value, payload_value_o);
          error_count++;
        end
        if (payload_position_o !== want.position) begin
          $error("payload_position: expected %0d, got %0d", want.position,
                 payload_position_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_frames();
    test_silence_timeouts();
    test_long_frames();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
